// ----- src/srm_pkg.sv -----
// Shared types, codes and defaults for the sensor running average monitor.
package srm_pkg;

  localparam int DEF_MAX_SENSORS = 32;
  localparam int DEF_AVG_LENGTH  = 5;

  localparam logic signed [15:0] LOW_LIMIT_RESET  = 16'sd2560;
  localparam logic signed [15:0] HIGH_LIMIT_RESET = 16'sd5120;

  localparam logic ACT_LOAD = 1'b0;

  localparam logic [1:0] CFG_LOW_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_HIGH_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNKNOWN = 2'd1,
    STATUS_FULL    = 2'd2
  } srm_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_RING,
    S_SUM,
    S_AVG_GO,
    S_AVG_WAIT
  } srm_state_t;

  typedef struct packed {
    logic load;
    logic full;
    logic miss;
    logic plain;
    logic avg;
  } srm_emit_t;

endpackage

// ----- src/srm_mean_unit.sv -----
// Three-stage divide of a ring sum by the ring length, truncating toward zero.
module srm_mean_unit #(
  parameter int AVG_LENGTH = srm_pkg::DEF_AVG_LENGTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic signed [16+$clog2(AVG_LENGTH):0]  sum,
  output logic signed [15:0]                     mean,
  output logic                                   done
);

  localparam int MW = 16 + $clog2(AVG_LENGTH);
  localparam logic [MW:0] RECIP = (MW+1)'((64'd1 << MW) / AVG_LENGTH);

  logic              neg;
  logic [MW-1:0]     mag;
  logic [MW-1:0]     q0;
  logic              v1;
  logic              v2;
  logic [2*MW:0]     prod;
  logic [MW:0]       qn;
  logic [MW:0]       rem;
  logic [MW-1:0]     qc;
  logic signed [MW:0] sq;

  // The reciprocal underestimates by less than one, so one correction step suffices.
  always_comb begin
    prod = (2*MW+1)'(mag) * (2*MW+1)'(RECIP);
    qn   = (MW+1)'((MW+1)'(q0) * (MW+1)'(AVG_LENGTH));
    rem  = {1'b0, mag} - qn;
    qc   = (rem >= (MW+1)'(AVG_LENGTH)) ? q0 + MW'(1) : q0;
    sq   = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= sum[MW];
      mag <= sum[MW] ? MW'(-sum) : MW'(sum);
    end
    if (v1) begin
      q0 <= prod[2*MW-1:MW];
    end
    if (v2) begin
      mean <= sq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule

// ----- src/sensor_running_average_monitor.sv -----
// Top level of the per-sensor running average monitor with threshold alarms.
//
// Usage. An item is taken on a rising edge with start high and busy low. With action at
// the load code it appends a sensor id and room pair to the sensor table; otherwise it is
// a reading for the sensor whose id is found first in the table. Exactly one result beat
// follows each item: done is high for a single cycle with status, echoes, mean, flags and
// the stored timestamp on their ports. The receiver cannot stall; a result is gone after
// that cycle. Busy falls in the same cycle as done, so the next item may start at once.
// A load passes through its load state to done. A reading runs the table search, which
// scans the entries in order up to the first match (all entries on a miss), then writes
// the sample into the ring; once the sensor's ring is full, summing the ring through its
// single read port and the three-stage reciprocal divide follow.
// Limits are written over a valid/ready port that is always ready; write them while idle.
// Reset (synchronous, active high) empties the table and restores the default limits. No
// clearing pass is needed: each entry's ring state is set up when the entry is loaded.
module sensor_running_average_monitor #(
  parameter int MAX_SENSORS = srm_pkg::DEF_MAX_SENSORS,
  parameter int AVG_LENGTH  = srm_pkg::DEF_AVG_LENGTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [15:0]        node_id,
  input  logic [15:0]        room_id,
  input  logic signed [15:0] reading,
  input  logic [31:0]        stamp,
  output logic               done,
  output logic [1:0]         status,
  output logic [15:0]        echo_sensor,
  output logic [15:0]        echo_room,
  output logic signed [15:0] mean,
  output logic               mean_ready,
  output logic               too_cold,
  output logic               too_hot,
  output logic [31:0]        last_stamp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW         = $clog2(MAX_SENSORS + 1);
  localparam int IW         = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int PW         = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;
  localparam int KW         = $clog2(AVG_LENGTH + 1);
  localparam int RING_DEPTH = MAX_SENSORS * AVG_LENGTH;
  localparam int RW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = 17 + $clog2(AVG_LENGTH);

  typedef struct packed {
    logic [15:0]   id;
    logic [15:0]   room;
    logic [PW-1:0] pos;
    logic          full;
    logic [31:0]   stamp;
  } srm_entry_t;

  srm_pkg::srm_state_t state;
  srm_pkg::srm_state_t state_next;
  srm_pkg::srm_emit_t  em;

  // Configuration.
  logic signed [15:0] low_limit;
  logic signed [15:0] high_limit;

  // Latched item.
  logic               in_action;
  logic [15:0]        in_sid;
  logic [15:0]        in_room;
  logic signed [15:0] in_sample;
  logic [31:0]        in_stamp;

  // Table and search.
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] cmp_idx;
  logic          cmp_v;
  logic          hit;
  srm_entry_t    ent_mem [MAX_SENSORS];
  srm_entry_t    ent_rd;
  srm_entry_t    ent_wdata;
  logic [IW-1:0] ent_waddr;
  logic          ent_wr_en;

  // Matched entry and its ring.
  srm_entry_t         rec;
  logic [IW-1:0]      hit_idx;
  logic [RW-1:0]      base;
  logic [PW-1:0]      pos_next;
  logic               full_next;
  logic               ring_wrap;
  logic signed [15:0] ring_mem [RING_DEPTH];
  logic signed [15:0] ring_rd;
  logic [RW-1:0]      ring_raddr;

  // Running sum over the ring.
  logic [KW-1:0]      sum_k;
  logic [KW-1:0]      sum_vk;
  logic               sum_v;
  logic               sum_last;
  logic signed [SUM_W-1:0] acc;

  logic               avg_go;
  logic signed [15:0] avg_mean;
  logic               mean_done;

  assign busy      = (state != srm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign hit       = cmp_v && (ent_rd.id == in_sid);
  assign sum_last  = (sum_vk == KW'(AVG_LENGTH - 1));
  assign avg_go    = (state == srm_pkg::S_AVG_GO);

  // The ring pointer wraps after the last slot; the ring counts as full from then on.
  assign ring_wrap  = (rec.pos == PW'(AVG_LENGTH - 1));
  assign pos_next   = ring_wrap ? '0 : rec.pos + PW'(1);
  assign full_next  = rec.full | ring_wrap;
  assign ring_raddr = base + RW'(sum_k);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    em         = '0;
    unique case (state)
      srm_pkg::S_IDLE: begin
        if (start) begin
          state_next = (action == srm_pkg::ACT_LOAD) ? srm_pkg::S_LOAD : srm_pkg::S_SEARCH;
        end
      end
      srm_pkg::S_LOAD: begin
        if (count == CW'(MAX_SENSORS)) begin
          em.full = 1'b1;
        end else begin
          em.load = 1'b1;
        end
        state_next = srm_pkg::S_IDLE;
      end
      srm_pkg::S_SEARCH: begin
        if (hit) begin
          state_next = srm_pkg::S_RING;
        end else if (scan_idx == count) begin
          em.miss    = 1'b1;
          state_next = srm_pkg::S_IDLE;
        end
      end
      srm_pkg::S_RING: begin
        if (full_next) begin
          state_next = srm_pkg::S_SUM;
        end else begin
          em.plain   = 1'b1;
          state_next = srm_pkg::S_IDLE;
        end
      end
      srm_pkg::S_SUM: begin
        if (sum_v && sum_last) begin
          state_next = srm_pkg::S_AVG_GO;
        end
      end
      srm_pkg::S_AVG_GO: begin
        state_next = srm_pkg::S_AVG_WAIT;
      end
      srm_pkg::S_AVG_WAIT: begin
        if (mean_done) begin
          em.avg     = 1'b1;
          state_next = srm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srm_pkg::S_IDLE;
      end
    endcase
  end

  // Entry table write: a load sets up a fresh entry, a reading updates ring state and stamp.
  always_comb begin
    ent_wr_en = 1'b0;
    ent_waddr = hit_idx;
    ent_wdata = '{id: rec.id, room: rec.room, pos: pos_next, full: full_next,
                  stamp: in_stamp};
    if (em.load) begin
      ent_wr_en = 1'b1;
      ent_waddr = count[IW-1:0];
      ent_wdata = '{id: in_sid, room: in_room, pos: '0, full: 1'b0, stamp: '0};
    end else if (state == srm_pkg::S_RING) begin
      ent_wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_wr_en) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd <= ent_mem[scan_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == srm_pkg::S_RING) begin
      ring_mem[base + RW'(rec.pos)] <= in_sample;
    end
    ring_rd <= ring_mem[ring_raddr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == srm_pkg::S_IDLE && start) begin
      in_action <= action;
      in_sid    <= node_id;
      in_room   <= room_id;
      in_sample <= reading;
      in_stamp  <= stamp;
      scan_idx  <= '0;
    end else if (state == srm_pkg::S_SEARCH && scan_idx < count) begin
      scan_idx <= scan_idx + CW'(1);
    end
    cmp_idx <= scan_idx;
    if (state == srm_pkg::S_SEARCH && hit) begin
      rec     <= ent_rd;
      hit_idx <= cmp_idx[IW-1:0];
      base    <= RW'(RW'(cmp_idx) * RW'(AVG_LENGTH));
    end
    if (state == srm_pkg::S_RING) begin
      acc   <= '0;
      sum_k <= '0;
    end else if (state == srm_pkg::S_SUM && sum_k < KW'(AVG_LENGTH)) begin
      sum_k <= sum_k + KW'(1);
    end
    sum_vk <= sum_k;
    if (sum_v) begin
      acc <= acc + SUM_W'(ring_rd);
    end

    if (em.load || em.full || em.miss) begin
      status      <= em.load ? srm_pkg::STATUS_OK :
                     (em.full ? srm_pkg::STATUS_FULL : srm_pkg::STATUS_UNKNOWN);
      echo_sensor <= in_sid;
      echo_room   <= em.load ? in_room : 16'd0;
      mean        <= '0;
      mean_ready  <= 1'b0;
      too_cold    <= 1'b0;
      too_hot     <= 1'b0;
      last_stamp  <= '0;
    end else if (em.plain || em.avg) begin
      status      <= srm_pkg::STATUS_OK;
      echo_sensor <= in_sid;
      echo_room   <= rec.room;
      mean        <= em.avg ? avg_mean : 16'sd0;
      mean_ready  <= em.avg;
      too_cold    <= em.avg && (avg_mean < low_limit);
      too_hot     <= em.avg && (avg_mean > high_limit);
      last_stamp  <= in_stamp;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cmp_v      <= 1'b0;
      sum_v      <= 1'b0;
      done       <= 1'b0;
      low_limit  <= srm_pkg::LOW_LIMIT_RESET;
      high_limit <= srm_pkg::HIGH_LIMIT_RESET;
    end else begin
      if (em.load) begin
        count <= count + CW'(1);
      end
      cmp_v <= (state == srm_pkg::S_SEARCH) && (scan_idx < count);
      sum_v <= (state == srm_pkg::S_SUM) && (sum_k < KW'(AVG_LENGTH));
      done  <= |em;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srm_pkg::CFG_LOW_LIMIT:  low_limit  <= cfg_data;
          srm_pkg::CFG_HIGH_LIMIT: high_limit <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  srm_mean_unit #(
    .AVG_LENGTH(AVG_LENGTH)
  ) u_mean (
    .clk  (clk),
    .rst  (rst),
    .go   (avg_go),
    .sum  (acc),
    .mean (avg_mean),
    .done (mean_done)
  );

`ifndef SYNTHESIS
  // A result beat always closes the item, so the block is free in that cycle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");

  // Every result beat ends a busy period.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without an item in progress");

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_SENSORS))
    else $error("entry count beyond table size");

  // Without a full ring, the mean and both alarms read as zero.
  assert property (@(posedge clk) disable iff (rst)
                   (done && !mean_ready) |-> (mean == 16'sd0 && !too_cold && !too_hot))
    else $error("mean or alarm set before ring full");

  // A load that fits grows the table by exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
                   (done && $past(in_action) == srm_pkg::ACT_LOAD &&
                    status == srm_pkg::STATUS_OK)
                   |-> count == $past(count) + CW'(1))
    else $error("load result without a new entry");
`endif

endmodule

// ----- tb/tb_sensor_running_average_monitor.sv -----
// Self-checking testbench for the per-sensor running average monitor with threshold alarms.
`timescale 1ns / 100ps

module tb_sensor_running_average_monitor;

  // Sizes of the block as built here. The predictor keeps its tables at the same depths.
  localparam int SENSOR_SLOTS = srm_pkg::DEF_MAX_SENSORS;
  localparam int RING_DEPTH   = srm_pkg::DEF_AVG_LENGTH;

  // The package names only the load code; the other value of action is a reading.
  localparam logic ACT_READ = ~srm_pkg::ACT_LOAD;

  // A reading in the worst case runs a full table search, the ring sum and the divide, and
  // the sender may hold back for a while on top of that. Reaching STALL_LIMIT with no beat moving means a hang.
  localparam int STALL_LIMIT = 2000;

  // Cycles allowed after the last expected result before the verdict is given.
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic               act;
    logic [15:0]        sid;
    logic [15:0]        room;
    logic signed [15:0] temp;
    logic [31:0]        ts;
  } sensor_item_t;

  typedef struct {
    srm_pkg::srm_status_t status;
    logic [15:0]          sensor;
    logic [15:0]          room;
    logic signed [15:0]   avg;
    logic                 ready;
    logic                 cold;
    logic                 hot;
    logic [31:0]          ts;
  } monitor_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               action;
  logic [15:0]        node_id;
  logic [15:0]        room_id;
  logic signed [15:0] reading;
  logic [31:0]        stamp;
  logic               done;
  logic [1:0]         status;
  logic [15:0]        echo_sensor;
  logic [15:0]        echo_room;
  logic signed [15:0] mean;
  logic               mean_ready;
  logic               too_cold;
  logic               too_hot;
  logic [31:0]        last_stamp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  sensor_running_average_monitor u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .node_id     (node_id),
    .room_id     (room_id),
    .reading     (reading),
    .stamp       (stamp),
    .done        (done),
    .status      (status),
    .echo_sensor (echo_sensor),
    .echo_room   (echo_room),
    .mean        (mean),
    .mean_ready  (mean_ready),
    .too_cold    (too_cold),
    .too_hot     (too_hot),
    .last_stamp  (last_stamp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Shadow copy of the block's state. It is updated in step with every accepted beat, so
  // that the expected result of each item can be worked out the moment it is taken.
  int                 sensor_count;
  logic [15:0]        sensor_ids   [SENSOR_SLOTS];
  logic [15:0]        sensor_rooms [SENSOR_SLOTS];
  logic signed [15:0] ring_samples [SENSOR_SLOTS][RING_DEPTH];
  int                 ring_slot    [SENSOR_SLOTS];
  logic               ring_filled  [SENSOR_SLOTS];
  logic signed [15:0] stored_mean  [SENSOR_SLOTS];
  logic [31:0]        stored_stamp [SENSOR_SLOTS];
  logic signed [15:0] low_threshold;
  logic signed [15:0] high_threshold;

  // Results still owed by the block, oldest first.
  monitor_result_t pending_results[$];

  int sender_idle_pct;
  int band_shift;
  int stall_cycles;
  int error_count;
  int items_sent;
  int limit_writes;
  int seen_loads;
  int seen_full;
  int seen_unknown;
  int seen_averaged;
  int seen_cold;
  int seen_hot;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one item and advances the shadow state, exactly as the block
  // is meant to: loads append to the table, readings go to the first entry with their id.
  function automatic monitor_result_t compute_monitor_result(input sensor_item_t it);
    monitor_result_t r;
    int              hit;
    int              i;
    int              sum;

    r.status = srm_pkg::STATUS_OK;
    r.sensor = it.sid;
    r.room   = '0;
    r.avg    = '0;
    r.ready  = 1'b0;
    r.cold   = 1'b0;
    r.hot    = 1'b0;
    r.ts     = '0;
    hit      = -1;
    sum      = 0;

    if (it.act == srm_pkg::ACT_LOAD) begin
      // A full table refuses the load and leaves everything as it was.
      if (sensor_count >= SENSOR_SLOTS) begin
        r.status = srm_pkg::STATUS_FULL;
      end else begin
        sensor_ids[sensor_count]   = it.sid;
        sensor_rooms[sensor_count] = it.room;
        ring_slot[sensor_count]    = 0;
        ring_filled[sensor_count]  = 1'b0;
        stored_mean[sensor_count]  = '0;
        stored_stamp[sensor_count] = '0;
        sensor_count++;
        seen_loads++;
        r.room = it.room;
      end
      return r;
    end

    // The search stops at the first entry with a matching id, so a duplicate later in the
    // table is never reached.
    for (i = 0; i < sensor_count; i++) begin
      if (sensor_ids[i] == it.sid) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) begin
      r.status = srm_pkg::STATUS_UNKNOWN;
      return r;
    end

    ring_samples[hit][ring_slot[hit]] = it.temp;
    if (ring_slot[hit] == RING_DEPTH - 1) begin
      ring_slot[hit]   = 0;
      ring_filled[hit] = 1'b1;
    end else begin
      ring_slot[hit]++;
    end
    stored_stamp[hit] = it.ts;

    // Signed integer division truncates toward zero, which is what the mean calls for.
    if (ring_filled[hit]) begin
      for (i = 0; i < RING_DEPTH; i++) sum += ring_samples[hit][i];
      stored_mean[hit] = 16'(sum / RING_DEPTH);
      r.avg  = stored_mean[hit];
      r.cold = r.avg < low_threshold;
      r.hot  = r.avg > high_threshold;
    end
    r.room  = sensor_rooms[hit];
    r.ready = ring_filled[hit];
    r.ts    = stored_stamp[hit];
    return r;
  endfunction

  // Offers one item to the block and waits until it is taken. Inputs move on the falling
  // edge only. While the block is busy, and after it falls, start is dropped at random for
  // whole cycles at the current idle rate, so acceptance drifts across every phase of the
  // block's work. Start is left high on return, so that a following item keeps it up.
  task automatic send_item(input logic act, input logic [15:0] sid, input logic [15:0] room,
                           input logic signed [15:0] temp, input logic [31:0] ts);
    sensor_item_t it;
    logic         taken;

    it    = '{act: act, sid: sid, room: room, temp: temp, ts: ts};
    taken = 1'b0;
    @(negedge clk);
    action    = act;
    node_id   = sid;
    room_id   = room;
    reading   = temp;
    stamp     = ts;
    while (!taken) begin
      start = ($urandom_range(99) >= sender_idle_pct);
      @(posedge clk);
      if (start && !busy) begin
        taken = 1'b1;
      end else begin
        @(negedge clk);
      end
    end
    pending_results.push_back(compute_monitor_result(it));
    items_sent++;
  endtask

  // Lowers start and waits until every owed result has come back. Each item causes a
  // result, so the block is idle once the queue is empty; an extra settling wait follows anyway.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one limit register over the configuration channel, only while the block is idle.
  task automatic write_limit(input logic [1:0] idx, input logic signed [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == srm_pkg::CFG_LOW_LIMIT) begin
      low_threshold = value;
    end else if (idx == srm_pkg::CFG_HIGH_LIMIT) begin
      high_threshold = value;
    end
    limit_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A reading on an empty table can match nothing and must report an unknown sensor.
  task automatic test_empty_table();
    send_item(ACT_READ, 16'h0000, 16'hffff, 16'sh7fff, 32'hffff_ffff);
  endtask

  // Loads of extreme ids and of one id twice with different rooms; a reading of an unknown id.
  task automatic test_loads_and_duplicates();
    send_item(srm_pkg::ACT_LOAD, 16'h0000, 16'hffff, 16'sh0000, 32'h0000_0000);
    send_item(srm_pkg::ACT_LOAD, 16'hffff, 16'h0000, 16'sh7fff, 32'hffff_ffff);
    send_item(srm_pkg::ACT_LOAD, 16'h1234, 16'h0101, -16'sd1, 32'h0000_0001);
    send_item(srm_pkg::ACT_LOAD, 16'h1234, 16'h0202, 16'sh0000, 32'h8000_0000);
    send_item(ACT_READ, 16'habcd, 16'h5555, 16'sh0100, 32'h1234_5678);
  endtask

  // Fills three rings. The first four readings of each come back without a mean; the fifth
  // brings the average in. The all-maximum ring must run hot, the all-minimum ring cold,
  // and a ring summing to minus seven must average to minus one, not minus two.
  task automatic test_ring_fill_and_truncation();
    int k;

    for (k = 0; k < RING_DEPTH; k++)
      send_item(ACT_READ, 16'h1234, 16'h0000, 16'sh7fff, (k == 2) ? 32'hffff_ffff : k);
    for (k = 0; k < RING_DEPTH; k++)
      send_item(ACT_READ, 16'hffff, 16'hffff, (k < 3) ? -16'sd1 : -16'sd2, 32'h0000_0010 + k);
    for (k = 0; k < RING_DEPTH; k++)
      send_item(ACT_READ, 16'h0000, 16'h0000, -16'sd32768, 32'hfffffff0 + k);
  endtask

  // Limits at opposite ends. With the widest window, a mean sitting exactly on a limit
  // must not raise its alarm; with the window turned inside out, both alarms fire at once.
  task automatic test_limit_extremes();
    wait_drained();
    write_limit(srm_pkg::CFG_LOW_LIMIT, -16'sd32768);
    write_limit(srm_pkg::CFG_HIGH_LIMIT, 16'sd32767);
    send_item(ACT_READ, 16'h0000, 16'h0000, -16'sd32768, 32'h0000_0100);
    send_item(ACT_READ, 16'h1234, 16'h0000, 16'sd32767, 32'h0000_0101);
    wait_drained();
    write_limit(srm_pkg::CFG_LOW_LIMIT, 16'sd32767);
    write_limit(srm_pkg::CFG_HIGH_LIMIT, -16'sd32768);
    send_item(ACT_READ, 16'hffff, 16'h0000, -16'sd1, 32'h0000_0102);
  endtask

  // Random traffic. Most beats are readings to sensors already in the table, so rings fill
  // and roll over. Each sensor keeps its readings around one band (near the low limit, near
  // the high limit, between them, or anywhere), so means land on both sides of each limit.
  // Loads come often until the table is full and rarely after, which then gives refusals;
  // a share of loads repeats a known id. Readings with random ids mostly miss the table.
  task automatic run_random_traffic(input int beats);
    int          n;
    int          roll;
    int          load_pct;
    int          idx;
    int          centre;
    int          val;
    logic [15:0] sid;

    for (n = 0; n < beats; n++) begin
      load_pct = (sensor_count < SENSOR_SLOTS) ? 12 : 3;
      roll     = $urandom_range(99);
      if (roll < load_pct) begin
        if (sensor_count > 0 && $urandom_range(3) == 0) begin
          sid = sensor_ids[$urandom_range(sensor_count - 1)];
        end else begin
          sid = 16'($urandom);
        end
        send_item(srm_pkg::ACT_LOAD, sid, 16'($urandom), 16'($urandom), $urandom);
      end else if (roll < load_pct + 8 || sensor_count == 0) begin
        send_item(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else begin
        idx = $urandom_range(sensor_count - 1);
        case ((idx + band_shift) % 4)
          0: begin
            centre = low_threshold;
          end
          1: begin
            centre = high_threshold;
          end
          2: begin
            centre = (int'(low_threshold) + int'(high_threshold)) / 2;
          end
          default: begin
            centre = int'($urandom_range(65535)) - 32768;
          end
        endcase
        val = centre + int'($urandom_range(767)) - 384;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        send_item(ACT_READ, sensor_ids[idx], 16'($urandom), 16'(val), $urandom);
      end
    end
    band_shift++;
  endtask

  // The sender holds back rarely; limits are a random window around room temperatures.
  task automatic test_random_sender_sparse();
    wait_drained();
    write_limit(srm_pkg::CFG_LOW_LIMIT, 16'(int'($urandom_range(4096)) + 1024));
    write_limit(srm_pkg::CFG_HIGH_LIMIT, 16'(int'($urandom_range(4096)) + 5120));
    sender_idle_pct = 10;
    run_random_traffic(410);
  endtask

  // The sender holds back most of the time; limits anywhere, possibly inside out.
  task automatic test_random_sender_heavy();
    wait_drained();
    write_limit(srm_pkg::CFG_LOW_LIMIT, 16'($urandom));
    write_limit(srm_pkg::CFG_HIGH_LIMIT, 16'($urandom));
    sender_idle_pct = 85;
    run_random_traffic(410);
  endtask

  // Items offered back to back, so each one is taken in the cycle that busy falls.
  task automatic test_random_back_to_back();
    wait_drained();
    write_limit(srm_pkg::CFG_LOW_LIMIT, 16'(int'($urandom_range(2048)) - 1024));
    write_limit(srm_pkg::CFG_HIGH_LIMIT, 16'(int'($urandom_range(2048)) + 1024));
    sender_idle_pct = 0;
    run_random_traffic(410);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Each result beat is on the ports for one cycle and is taken at the edge ending it, so
  // it is compared field by field with the oldest owed result at that edge.
  always @(posedge clk) begin : result_checker
    monitor_result_t want;

    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat for sensor %0h with nothing expected", $time,
                 echo_sensor);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("echo_sensor", want.sensor, echo_sensor);
        check_field("echo_room", want.room, echo_room);
        check_field("mean", want.avg, mean);
        check_field("mean_ready", want.ready, mean_ready);
        check_field("too_cold", want.cold, too_cold);
        check_field("too_hot", want.hot, too_hot);
        check_field("last_stamp", want.ts, last_stamp);
        case (want.status)
          srm_pkg::STATUS_FULL: begin
            seen_full++;
          end
          srm_pkg::STATUS_UNKNOWN: begin
            seen_unknown++;
          end
          default: begin
          end
        endcase
        if (want.ready) seen_averaged++;
        if (want.cold) seen_cold++;
        if (want.hot) seen_hot++;
      end
    end
  end

  // Any beat that moves, item, result or register write, resets the stall count.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results still owed", $time,
               stall_cycles, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Every input is known from time zero; reset is held from the start and then released
    // on a falling edge, never to be raised again.
    rst             = 1'b1;
    start           = 1'b0;
    action          = srm_pkg::ACT_LOAD;
    node_id         = '0;
    room_id         = '0;
    reading         = '0;
    stamp           = '0;
    cfg_valid       = 1'b0;
    cfg_index       = srm_pkg::CFG_LOW_LIMIT;
    cfg_data        = '0;
    sensor_count    = 0;
    low_threshold   = srm_pkg::LOW_LIMIT_RESET;
    high_threshold  = srm_pkg::HIGH_LIMIT_RESET;
    sender_idle_pct = 10;
    band_shift      = 0;
    stall_cycles    = 0;
    error_count     = 0;
    items_sent      = 0;
    limit_writes    = 0;
    seen_loads      = 0;
    seen_full       = 0;
    seen_unknown    = 0;
    seen_averaged   = 0;
    seen_cold       = 0;
    seen_hot        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The directed part runs on the reset limits until the limit test rewrites them.
    test_empty_table();
    test_loads_and_duplicates();
    test_ring_fill_and_truncation();
    test_limit_extremes();
    test_random_sender_sparse();
    test_random_sender_heavy();
    test_random_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d loads taken, %0d refused on a full table, %0d unknown ids.",
             items_sent, seen_loads, seen_full, seen_unknown);
    $display("%0d results carried a mean (%0d cold, %0d hot); limits written %0d times.",
             seen_averaged, seen_cold, seen_hot, limit_writes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sensor_running_average_monitor.f -----
src/srm_pkg.sv
src/srm_mean_unit.sv
src/sensor_running_average_monitor.sv
tb/tb_sensor_running_average_monitor.sv
